// File: rtl/bad_pkg.sv
package bad_pkg;

    localparam int MAX_BLOCK_COLS = 64;
    localparam int MAX_TILE_EDGE  = 16;
    localparam int MAX_ROW_PIXELS = 1024;

    localparam int COL_W   = $clog2(MAX_BLOCK_COLS);
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 9;
    localparam int QUO_W   = 8;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_EDGE    = 2'd2;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd29;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd6;
    localparam logic [4:0]  RST_TILE_EDGE    = 5'd3;

    typedef struct packed {
        logic accept;
        logic acc_wr;
        logic emit_init;
        logic emit_rd;
        logic div_start;
        logic out_load;
        logic next_col;
    } bad_cmd_t;

    typedef struct packed {
        logic flush;
        logic emit;
        logic div_done;
        logic last_col;
    } bad_stat_t;

endpackage

// File: rtl/bad_div.sv
module bad_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [16:0]              num,
    input  logic [9:0]               den,
    output logic                     done,
    output logic [bad_pkg::QUO_W-1:0] quo
);

    // Restoring division; the quotient is known to fit in QUO_W bits.
    logic [16:0]               rem_reg,  rem_next;
    logic [16:0]               dsh_reg,  dsh_next;
    logic [bad_pkg::QUO_W-1:0] quo_reg,  quo_next;
    logic [3:0]                step_reg, step_next;
    logic                      done_reg, done_next;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = num;
            dsh_next  = {den, 7'd0};
            step_next = 4'(bad_pkg::QUO_W);
            done_next = 1'b0;
        end else if (step_reg != 4'd0) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[bad_pkg::QUO_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[bad_pkg::QUO_W-2:0], 1'b0};
            end
            dsh_next  = {1'b0, dsh_reg[16:1]};
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd1) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 4'd0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/bad_datapath.sv
module bad_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    input  logic [7:0]        pixel,
    input  bad_pkg::bad_cmd_t cmd,
    output bad_pkg::bad_stat_t stat,
    output logic [7:0]        block_average,
    output logic [5:0]        block_column,
    output logic [15:0]       block_row,
    output logic              last
);

    localparam int NCOL = bad_pkg::MAX_BLOCK_COLS;
    localparam int CW   = bad_pkg::COL_W;

    // Configuration registers.
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [4:0]  bsize_reg;

    // Raster position and the partial tile row.
    logic [9:0]    col_reg;
    logic [15:0]   row_reg;
    logic [3:0]    rib_reg;
    logic [15:0]   brow_reg;
    logic [3:0]    pit_reg;
    logic [11:0]   rsum_reg;
    logic [CW-1:0] tile_reg;

    // Pending accumulation and emission context.
    logic [11:0]   acc_sum_reg;
    logic [4:0]    acc_cnt_reg;
    logic [CW-1:0] acc_addr_reg;
    logic [CW-1:0] last_col_reg;
    logic [15:0]   emit_row_reg;
    logic [CW-1:0] k_reg;

    // Tile accumulators; an entry without its valid bit reads as zero.
    logic [bad_pkg::SUM_W-1:0] sum_mem [NCOL];
    logic [bad_pkg::CNT_W-1:0] cnt_mem [NCOL];
    logic [NCOL-1:0]           valid_reg;
    logic [bad_pkg::SUM_W-1:0] rd_sum_reg;
    logic [bad_pkg::CNT_W-1:0] rd_cnt_reg;
    logic                      rd_vld_reg;
    logic [CW-1:0]             rd_addr;

    logic                      zero_reg;
    logic [7:0]                avg_reg;
    logic [5:0]                col_out_reg;
    logic [15:0]               row_out_reg;
    logic                      last_out_reg;

    logic [4:0]  b_eff;
    logic [10:0] w_lim;
    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic        row_end;
    logic        row_last;
    logic        blk_end;
    logic [4:0]  pit_new;
    logic [11:0] rsum_new;
    logic        flush;

    logic [bad_pkg::SUM_W-1:0] base_sum;
    logic [bad_pkg::CNT_W-1:0] base_cnt;
    logic [16:0]               div_num;
    logic [9:0]                div_den;
    logic                      div_done;
    logic [bad_pkg::QUO_W-1:0] div_quo;

    always_comb begin
        if (bsize_reg == 5'd0) begin
            b_eff = 5'd1;
        end else if (bsize_reg > 5'(bad_pkg::MAX_TILE_EDGE)) begin
            b_eff = 5'(bad_pkg::MAX_TILE_EDGE);
        end else begin
            b_eff = bsize_reg;
        end
        w_lim = {b_eff, 6'd0};
        w_eff = (width_reg == 11'd0) ? 11'd1 : width_reg;
        if (w_eff > w_lim) begin
            w_eff = w_lim;
        end
        if (w_eff > 11'(bad_pkg::MAX_ROW_PIXELS)) begin
            w_eff = 11'(bad_pkg::MAX_ROW_PIXELS);
        end
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    end

    assign row_end  = ({1'b0, col_reg} + 11'd1) >= w_eff;
    assign row_last = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};
    assign blk_end  = ({1'b0, rib_reg} + 5'd1) == b_eff;
    assign pit_new  = {1'b0, pit_reg} + 5'd1;
    assign rsum_new = rsum_reg + {4'd0, pixel};
    assign flush    = (pit_new >= b_eff) || row_end;

    assign stat.flush    = flush;
    assign stat.emit     = row_end && (blk_end || row_last);
    assign stat.div_done = div_done;
    assign stat.last_col = (k_reg == last_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bad_pkg::RST_IMAGE_WIDTH;
            height_reg <= bad_pkg::RST_IMAGE_HEIGHT;
            bsize_reg  <= bad_pkg::RST_TILE_EDGE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bad_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[10:0];
                bad_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                bad_pkg::REG_TILE_EDGE:    bsize_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Any configuration write restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            col_reg  <= '0;
            row_reg  <= '0;
            rib_reg  <= '0;
            brow_reg <= '0;
            pit_reg  <= '0;
            rsum_reg <= '0;
            tile_reg <= '0;
            k_reg    <= '0;
        end else begin
            if (cmd.accept) begin
                if (flush) begin
                    rsum_reg <= '0;
                    pit_reg  <= '0;
                    tile_reg <= row_end ? '0 : tile_reg + CW'(1);
                end else begin
                    rsum_reg <= rsum_new;
                    pit_reg  <= pit_new[3:0];
                end
                if (!row_end) begin
                    col_reg <= col_reg + 10'd1;
                end else begin
                    col_reg <= '0;
                    if (row_last) begin
                        row_reg  <= '0;
                        rib_reg  <= '0;
                        brow_reg <= '0;
                    end else begin
                        row_reg <= row_reg + 16'd1;
                        if (blk_end) begin
                            rib_reg  <= '0;
                            brow_reg <= brow_reg + 16'd1;
                        end else begin
                            rib_reg <= rib_reg + 4'd1;
                        end
                    end
                end
            end
            if (cmd.emit_init) begin
                k_reg <= '0;
            end else if (cmd.next_col) begin
                k_reg <= k_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            acc_sum_reg  <= rsum_new;
            acc_cnt_reg  <= pit_new;
            acc_addr_reg <= tile_reg;
            if (row_end) begin
                last_col_reg <= tile_reg;
                emit_row_reg <= brow_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            valid_reg <= '0;
        end else begin
            if (cmd.acc_wr) begin
                valid_reg[acc_addr_reg] <= 1'b1;
            end
            if (cmd.emit_rd) begin
                valid_reg[k_reg] <= 1'b0;
            end
        end
    end

    assign rd_addr  = cmd.emit_rd ? k_reg : tile_reg;
    assign base_sum = rd_vld_reg ? rd_sum_reg : '0;
    assign base_cnt = rd_vld_reg ? rd_cnt_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.acc_wr) begin
            sum_mem[acc_addr_reg] <= base_sum + {4'd0, acc_sum_reg};
            cnt_mem[acc_addr_reg] <= base_cnt + {4'd0, acc_cnt_reg};
        end
        rd_sum_reg <= sum_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
        rd_vld_reg <= valid_reg[rd_addr];
    end

    // Half-up rounding: (2*sum + count) / (2*count).
    assign div_num = {base_sum, 1'b0} + {8'd0, base_cnt};
    assign div_den = {base_cnt, 1'b0};

    bad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            zero_reg <= (base_cnt == '0);
        end
        if (cmd.out_load) begin
            avg_reg      <= zero_reg ? 8'd0 : div_quo;
            col_out_reg  <= 6'(k_reg);
            row_out_reg  <= emit_row_reg;
            last_out_reg <= (k_reg == last_col_reg);
        end
    end

    assign block_average = avg_reg;
    assign block_column  = col_out_reg;
    assign block_row     = row_out_reg;
    assign last          = last_out_reg;

endmodule

// File: rtl/bad_ctrl.sv
module bad_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  bad_pkg::bad_stat_t stat,
    output bad_pkg::bad_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_DIVST = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       emit_pend_reg, emit_pend_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next     = state_reg;
        emit_pend_next = emit_pend_reg;
        m_valid_next   = m_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept     = 1'b1;
                    emit_pend_next = stat.emit;
                    if (stat.flush) begin
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC: begin
                cmd.acc_wr = 1'b1;
                if (emit_pend_reg) begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = S_DIVST;
            end
            S_DIVST: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (stat.last_col) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_col = 1'b1;
                        state_next   = S_RD;
                    end
                end
            end
            default: begin
                state_next   = S_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            emit_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            emit_pend_reg <= emit_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/block_average_downsampler.sv
// Block-average downsampler. Pixels come in on the s_ channel (s_pixel) in
// raster order, one request per pixel. Each square tile of the configured edge
// length is summed into one of 64 column accumulators; tiles cut by the right
// or bottom edge are averaged over the pixels they hold.
// A pixel that closes a tile row holds off the next pixel for a write-back,
// as the accumulator memory is read with it and written back the next cycle.
// The pixel that ends a block row (or the frame's last row) starts an emission
// burst: one m_ request per block column, in column order, with m_last on the
// final one. Each result passes through a memory read, a divider start, eight
// divide steps, the output register load and its turn on the output, plus any
// time the receiver holds m_ready low. No pixel is taken during a burst; a
// stalled result simply holds.
// The cfg_ port writes image_width (0), image_height (1) and the tile edge (2);
// every write restarts the frame and clears all accumulators at once.
// Reset restores width 29, height 6, tile edge 3 and an empty frame.
module block_average_downsampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_block_average,
    output logic [5:0]  m_block_column,
    output logic [15:0] m_block_row,
    output logic        m_last
);

    bad_pkg::bad_cmd_t  cmd;
    bad_pkg::bad_stat_t stat;

    bad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bad_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pixel         (s_pixel),
        .cmd           (cmd),
        .stat          (stat),
        .block_average (m_block_average),
        .block_column  (m_block_column),
        .block_row     (m_block_row),
        .last          (m_last)
    );

`ifndef ASSERT_OFF
    // Input and output never run at the same time.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // After a result that is not the last, the burst goes on.
    a_burst_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !s_ready)
        else $error("burst ended before the last column");

    // A pixel that triggers emission always closes a tile.
    a_emit_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.emit) |-> stat.flush)
        else $error("emission without tile flush");

    // Starting the divider clears its done flag.
    a_div_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !stat.div_done)
        else $error("divider done right after start");
`endif

endmodule
